// File: rtl/core/mbp_pkg.sv
// Shared types and constants for the MSB-first bit/byte packer.
// No dependencies; every other file of the block imports this package.
package mbp_pkg;

	localparam int BYTE_W    = 8;
	localparam int VALUE_W   = 64;
	localparam int COUNT_W   = 6;
	localparam int REM_W     = 7;   // bit count still to pack, 0..64
	localparam int BYTES_MAX = 8;

	typedef enum logic [1:0] {
		FUNC_ADD_BITS  = 2'd0,
		FUNC_ADD_BYTES = 2'd1,
		FUNC_FLUSH     = 2'd2
	} func_t;

	// control handed from the packing datapath to the output stage
	typedef struct packed {
		logic load;
		logic last;
	} emit_t;

endpackage

// File: rtl/core/mbp_if.sv
// Channel interfaces of the packer: input items and output byte items.
// Depends on mbp_pkg for the field widths.
interface mbp_in_if import mbp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [VALUE_W-1:0] value;
	logic [COUNT_W-1:0] count;

	modport source(output valid, output func, output value, output count, input ready);
	modport sink(input valid, input func, input value, input count, output ready);
endinterface

interface mbp_out_if import mbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_of_run;

	modport source(output valid, output out_byte, output last_of_run, input ready);
	modport sink(input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/core/mbp_out_stage.sv
// Output register of the packer: holds one byte item until the sink takes it.
// Depends on mbp_pkg (emit_t) and mbp_if (mbp_out_if).
module mbp_out_stage import mbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  emit_t             emit,
	input  logic [BYTE_W-1:0] byte_in,
	output logic              free,
	mbp_out_if.source         out_ch
);

	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;

	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.load) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			byte_q <= byte_in;
			last_q <= emit.last;
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.out_byte    = byte_q;
	assign out_ch.last_of_run = last_q;

endmodule

// File: rtl/core/msb_first_bit_byte_packer.sv
// Steps: an item is taken, then each byte step emits one byte; add-bytes and flush first run
// a pad step that zero-pads a pending partial byte, and a closing step parks leftover bits
// and ends the item. An unknown function is taken and dropped. The first byte is loaded by
// the pad step when it finds a partial byte pending, else by the first byte step; each step
// waits while the output register is held by a stalled sink: one byte per cycle.
// Reset (arst_n, asynchronous): no partial byte pending, no item in work, output empty.
module msb_first_bit_byte_packer import mbp_pkg::*; #(
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	mbp_in_if.sink    in_ch,
	mbp_out_if.source out_ch
);

	localparam logic [REM_W-1:0] MAX_BITS = REM_W'(MAX_FIELD_BITS);
	localparam logic [REM_W-1:0] FULL_W   = REM_W'(VALUE_W);

	// item in work
	logic               busy_q;
	logic               pad_q;    // pad step still to do
	logic [REM_W-1:0]   rem_q;    // field bits not yet packed
	logic [VALUE_W-1:0] val_q;    // field bits, MSB-aligned
	// stream state
	logic [2:0]         fill_q;
	logic [BYTE_W-1:0]  part_q;   // pending bits, right-aligned, upper bits zero

	logic               accept;
	logic               ld_go;
	logic               ld_pad;
	logic [REM_W-1:0]   ld_rem;
	logic [VALUE_W-1:0] ld_val;
	logic [REM_W-1:0]   nb_bits;
	logic [3:0]         nb_bytes;

	logic               free;
	logic               step;
	emit_t              emit;
	logic [BYTE_W-1:0]  emit_byte;

	logic [3:0]         take;     // bits taken from val_q to finish a byte: 8 - fill
	logic [7:0]         total;
	logic [15:0]        cat_sh;
	logic [15:0]        pad_sh;
	logic [15:0]        abs_sh;
	logic [REM_W-1:0]   rem_next;

	assign in_ch.ready = !busy_q;
	assign accept      = in_ch.valid && in_ch.ready;

	// load decode; counts saturate, field is MSB-aligned by one shift
	always_comb begin
		nb_bits  = ({1'b0, in_ch.count} > MAX_BITS) ? MAX_BITS : {1'b0, in_ch.count};
		nb_bytes = (in_ch.count > COUNT_W'(BYTES_MAX)) ? 4'(BYTES_MAX) : in_ch.count[3:0];
		ld_go    = 1'b0;
		ld_pad   = 1'b0;
		ld_rem   = '0;
		case (func_t'(in_ch.func))
			FUNC_ADD_BITS: begin
				ld_go  = 1'b1;
				ld_rem = nb_bits;
			end
			FUNC_ADD_BYTES: begin
				ld_go  = 1'b1;
				ld_pad = 1'b1;
				ld_rem = {nb_bytes, 3'b000};
			end
			FUNC_FLUSH: begin
				ld_go  = 1'b1;
				ld_pad = 1'b1;
			end
			default: begin
				ld_go = 1'b0;
			end
		endcase
		ld_val = in_ch.value << (FULL_W - ld_rem);
	end

	// at most one byte digit per step
	assign step     = busy_q && free;
	assign take     = 4'd8 - {1'b0, fill_q};
	assign total    = {5'b0, fill_q} + {1'b0, rem_q};
	assign cat_sh   = {part_q, val_q[VALUE_W-1 -: BYTE_W]} << take;
	assign pad_sh   = {8'h00, part_q} << take;
	assign abs_sh   = {part_q, val_q[VALUE_W-1 -: BYTE_W]} << rem_q[2:0];
	assign rem_next = rem_q - {3'b000, take};

	always_comb begin
		emit      = '0;
		emit_byte = cat_sh[15:8];
		if (step) begin
			if (pad_q) begin
				// zero-pad a pending partial byte; bits follow at a byte boundary
				emit.load = (fill_q != 3'd0);
				emit.last = (rem_q < REM_W'(BYTE_W));
				emit_byte = pad_sh[7:0];
			end else if (total >= 8'd8) begin
				emit.load = 1'b1;
				emit.last = (rem_next < REM_W'(BYTE_W));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pad_q  <= 1'b0;
			rem_q  <= '0;
			fill_q <= '0;
			part_q <= '0;
		end else if (accept) begin
			busy_q <= ld_go;
			pad_q  <= ld_pad;
			rem_q  <= ld_rem;
		end else if (step) begin
			if (pad_q) begin
				pad_q  <= 1'b0;
				fill_q <= '0;
				part_q <= '0;
			end else if (total >= 8'd8) begin
				rem_q  <= rem_next;
				fill_q <= '0;
				part_q <= '0;
			end else begin
				// fewer than a byte left: park the bits and close the item
				part_q <= abs_sh[15:8];
				fill_q <= fill_q + rem_q[2:0];
				rem_q  <= '0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= ld_val;
		end else if (step && !pad_q && total >= 8'd8) begin
			val_q <= val_q << take;
		end
	end

	mbp_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.emit    (emit),
		.byte_in (emit_byte),
		.free    (free),
		.out_ch  (out_ch)
	);

	// a finished item leaves its final byte marked last
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && out_ch.valid) |-> out_ch.last_of_run)
		else $error("idle with a pending byte not marked last");

	// pad step only belongs to an item in work
	a_pad_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q |-> busy_q)
		else $error("pad pending without an item");

	// bit count never exceeds the shift register
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= FULL_W)
		else $error("bit count out of range");

	// pending bits stay right-aligned under the fill count
	a_part_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(part_q >> fill_q) == 8'h00)
		else $error("stray bits above the fill count");

	// a byte is emitted only while the output can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> (busy_q && free))
		else $error("byte emitted into a full output register");

endmodule
